// ===== rtl/core/ffha_pkg.sv =====
// ffha_pkg: shared types and constants of the first-fit heap allocator
// used by ffha_ctrl, ffha_dpath, first_fit_heap_allocator, ffha_checker and tb; no dependencies
package ffha_pkg;

   // header layout
   localparam logic [31:0] HDR_BYTES  = 32'd12;
   localparam logic [31:0] HDR_ADDR_MAX = 32'hFFFF_FFF3;

   // request kinds
   typedef enum logic [1:0] {
      KIND_INIT  = 2'd0,
      KIND_ALLOC = 2'd1,
      KIND_FREE  = 2'd2,
      KIND_NOP   = 2'd3
   } kind_type;

   // result status codes
   typedef enum logic [2:0] {
      ST_DONE    = 3'd0,
      ST_OOM     = 3'd1,
      ST_ABSENT  = 3'd2,
      ST_INVALID = 3'd3,
      ST_IGNORED = 3'd4,
      ST_SMALL   = 3'd5
   } status_type;

   // header address sources
   typedef enum logic [2:0] {
      ADR_BASE  = 3'd0,
      ADR_CUR   = 3'd1,
      ADR_NA    = 3'd2,
      ADR_ANEXT = 3'd3,
      ADR_APREV = 3'd4
   } adr_sel_type;

   // header write data sources
   typedef enum logic [2:0] {
      WS_INIT = 3'd0,
      WS_NEW  = 3'd1,
      WS_A    = 3'd2,
      WS_B    = 3'd3,
      WS_SPN  = 3'd4,
      WS_SPV  = 3'd5
   } wsel_type;

   // value written into a prev link by a relink
   typedef enum logic [1:0] {
      SPV_NA    = 2'd0,
      SPV_CUR   = 2'd1,
      SPV_APREV = 2'd2
   } spv_sel_type;

   // controller to datapath commands
   typedef struct packed {
      logic        load_req;
      adr_sel_type addr_sel;
      logic [1:0]  word;
      logic        mem_rd;
      logic        mem_wr;
      wsel_type    wsel;
      logic        cap;
      logic        cap_b;
      logic        set_ready;
      logic        clr_ready;
      logic        cur_from_base;
      logic        cur_from_ptr;
      logic        cur_from_anext;
      logic        step_clr;
      logic        step_inc;
      logic        na_load;
      logic        split_upd;
      logic        a_set_used;
      logic        a_clr_used;
      logic        merge_next;
      logic        merge_prev;
      logic        sp_load;
      spv_sel_type spv_sel;
      logic        finish;
      status_type  status;
      logic        give_ptr;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      kind_type kind;
      logic     init_small;
      logic     base_zero;
      logic     ready;
      logic     req_zero;
      logic     req_big;
      logic     ptr_low;
      logic     cur_zero;
      logic     cur_ok;
      logic     steps_done;
      logic     fit;
      logic     split_want;
      logic     na_ok;
      logic     a_used;
      logic     a_next_nz;
      logic     a_prev_nz;
      logic     b_used;
   } stat_type;

endpackage

// ===== rtl/core/ffha_ctrl.sv =====
// ffha_ctrl: sequencer of the heap allocator; walks headers through the datapath
// depends on ffha_pkg
module ffha_ctrl
   import ffha_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   output logic     busy,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [19:0] {
      S_IDLE  = 20'h00001,
      S_CHECK = 20'h00002,
      S_ALOOP = 20'h00004,
      S_ATEST = 20'h00008,
      S_ANA   = 20'h00010,
      S_ASPL  = 20'h00020,
      S_AFIN  = 20'h00040,
      S_OK    = 20'h00080,
      S_FCHK  = 20'h00100,
      S_FUSED = 20'h00200,
      S_FNX   = 20'h00400,
      S_FNX2  = 20'h00800,
      S_FPV   = 20'h01000,
      S_FPB   = 20'h02000,
      S_FPB2  = 20'h04000,
      S_FPB3  = 20'h08000,
      S_RD    = 20'h10000,
      S_WR    = 20'h20000,
      S_SP    = 20'h40000,
      S_ASPU  = 20'h80000
   } state_type;

   state_type   state_ff, state_in;
   state_type   ret_ff, ret_in;
   logic [1:0]  wcnt_ff, wcnt_in;
   adr_sel_type asel_ff, asel_in;
   wsel_type    wsel_ff, wsel_in;
   logic        dstb_ff, dstb_in;

   assign busy = (state_ff != S_IDLE);

   // state, return point and sub-sequence registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= S_IDLE;
         wcnt_ff  <= 2'd0;
         asel_ff  <= ADR_BASE;
         wsel_ff  <= WS_INIT;
         dstb_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         wcnt_ff  <= wcnt_in;
         asel_ff  <= asel_in;
         wsel_ff  <= wsel_in;
         dstb_ff  <= dstb_in;
      end
   end

   // next state and command decode
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      ret_in   = ret_ff;
      wcnt_in  = wcnt_ff;
      asel_in  = asel_ff;
      wsel_in  = wsel_ff;
      dstb_in  = dstb_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load_req = 1'b1;
               state_in     = S_CHECK;
            end
         end
         S_CHECK: begin
            case (stat.kind)
               KIND_INIT: begin
                  if (stat.init_small) begin
                     cmd.finish = 1'b1;
                     cmd.status = ST_SMALL;
                     state_in   = S_IDLE;
                  end else if (stat.base_zero) begin
                     cmd.clr_ready = 1'b1;
                     cmd.finish    = 1'b1;
                     cmd.status    = ST_ABSENT;
                     state_in      = S_IDLE;
                  end else begin
                     cmd.set_ready = 1'b1;
                     asel_in       = ADR_BASE;
                     wsel_in       = WS_INIT;
                     ret_in        = S_OK;
                     wcnt_in       = 2'd0;
                     state_in      = S_WR;
                  end
               end
               KIND_ALLOC: begin
                  if (!stat.ready || stat.req_zero) begin
                     cmd.finish = 1'b1;
                     cmd.status = ST_ABSENT;
                     state_in   = S_IDLE;
                  end else if (stat.req_big) begin
                     cmd.finish = 1'b1;
                     cmd.status = ST_OOM;
                     state_in   = S_IDLE;
                  end else begin
                     cmd.cur_from_base = 1'b1;
                     cmd.step_clr      = 1'b1;
                     state_in          = S_ALOOP;
                  end
               end
               KIND_FREE: begin
                  if (!stat.ready) begin
                     cmd.finish = 1'b1;
                     cmd.status = ST_ABSENT;
                     state_in   = S_IDLE;
                  end else if (stat.ptr_low) begin
                     cmd.finish = 1'b1;
                     cmd.status = ST_IGNORED;
                     state_in   = S_IDLE;
                  end else begin
                     cmd.cur_from_ptr = 1'b1;
                     state_in         = S_FCHK;
                  end
               end
               default: begin
                  cmd.finish = 1'b1;
                  cmd.status = ST_DONE;
                  state_in   = S_IDLE;
               end
            endcase
         end
         // allocate: first-fit walk
         S_ALOOP: begin
            if (stat.cur_zero || stat.steps_done) begin
               cmd.finish = 1'b1;
               cmd.status = ST_OOM;
               state_in   = S_IDLE;
            end else begin
               cmd.step_inc = 1'b1;
               asel_in      = ADR_CUR;
               dstb_in      = 1'b0;
               ret_in       = S_ATEST;
               wcnt_in      = 2'd0;
               state_in     = S_RD;
            end
         end
         S_ATEST: begin
            if (stat.fit) begin
               cmd.na_load = 1'b1;
               state_in    = stat.split_want ? S_ANA : S_AFIN;
            end else begin
               cmd.cur_from_anext = 1'b1;
               state_in           = S_ALOOP;
            end
         end
         S_ANA: begin
            if (stat.na_ok) begin
               asel_in  = ADR_NA;
               wsel_in  = WS_NEW;
               ret_in   = S_ASPL;
               wcnt_in  = 2'd0;
               state_in = S_WR;
            end else begin
               state_in = S_AFIN;
            end
         end
         // relink the old next block while the next link still points at it
         S_ASPL: begin
            if (stat.a_next_nz) begin
               cmd.sp_load = 1'b1;
               cmd.spv_sel = SPV_NA;
               ret_in      = S_ASPU;
               wcnt_in     = 2'd0;
               state_in    = S_SP;
            end else begin
               state_in = S_ASPU;
            end
         end
         // shrink the block and point it at the split-off part
         S_ASPU: begin
            cmd.split_upd = 1'b1;
            state_in      = S_AFIN;
         end
         S_AFIN: begin
            cmd.a_set_used = 1'b1;
            asel_in        = ADR_CUR;
            wsel_in        = WS_A;
            ret_in         = S_OK;
            wcnt_in        = 2'd0;
            state_in       = S_WR;
         end
         S_OK: begin
            cmd.finish   = 1'b1;
            cmd.status   = ST_DONE;
            cmd.give_ptr = (stat.kind == KIND_ALLOC);
            state_in     = S_IDLE;
         end
         // free: validate, then coalesce with neighbors
         S_FCHK: begin
            if (!stat.cur_ok) begin
               cmd.finish = 1'b1;
               cmd.status = ST_INVALID;
               state_in   = S_IDLE;
            end else begin
               asel_in  = ADR_CUR;
               dstb_in  = 1'b0;
               ret_in   = S_FUSED;
               wcnt_in  = 2'd0;
               state_in = S_RD;
            end
         end
         S_FUSED: begin
            if (!stat.a_used) begin
               cmd.finish = 1'b1;
               cmd.status = ST_INVALID;
               state_in   = S_IDLE;
            end else begin
               cmd.a_clr_used = 1'b1;
               if (stat.a_next_nz) begin
                  asel_in  = ADR_ANEXT;
                  dstb_in  = 1'b1;
                  ret_in   = S_FNX;
                  wcnt_in  = 2'd0;
                  state_in = S_RD;
               end else begin
                  state_in = S_FPV;
               end
            end
         end
         S_FNX: begin
            if (!stat.b_used) begin
               cmd.merge_next = 1'b1;
               state_in       = S_FNX2;
            end else begin
               state_in = S_FPV;
            end
         end
         S_FNX2: begin
            if (stat.a_next_nz) begin
               cmd.sp_load = 1'b1;
               cmd.spv_sel = SPV_CUR;
               ret_in      = S_FPV;
               wcnt_in     = 2'd0;
               state_in    = S_SP;
            end else begin
               state_in = S_FPV;
            end
         end
         S_FPV: begin
            wcnt_in = 2'd0;
            if (stat.a_prev_nz) begin
               asel_in  = ADR_APREV;
               dstb_in  = 1'b1;
               ret_in   = S_FPB;
               state_in = S_RD;
            end else begin
               asel_in  = ADR_CUR;
               wsel_in  = WS_A;
               ret_in   = S_OK;
               state_in = S_WR;
            end
         end
         S_FPB: begin
            if (!stat.b_used) begin
               cmd.merge_prev = 1'b1;
               state_in       = S_FPB2;
            end else begin
               asel_in  = ADR_CUR;
               wsel_in  = WS_A;
               ret_in   = S_OK;
               wcnt_in  = 2'd0;
               state_in = S_WR;
            end
         end
         S_FPB2: begin
            if (stat.a_next_nz) begin
               cmd.sp_load = 1'b1;
               cmd.spv_sel = SPV_APREV;
               ret_in      = S_FPB3;
               wcnt_in     = 2'd0;
               state_in    = S_SP;
            end else begin
               state_in = S_FPB3;
            end
         end
         S_FPB3: begin
            asel_in  = ADR_APREV;
            wsel_in  = WS_B;
            ret_in   = S_OK;
            wcnt_in  = 2'd0;
            state_in = S_WR;
         end
         // read three header words, capturing each in the cycle after its read
         S_RD: begin
            cmd.addr_sel = asel_ff;
            cmd.word     = wcnt_ff;
            cmd.mem_rd   = (wcnt_ff != 2'd3);
            cmd.cap      = (wcnt_ff != 2'd0);
            cmd.cap_b    = dstb_ff;
            wcnt_in      = wcnt_ff + 2'd1;
            if (wcnt_ff == 2'd3) begin
               state_in = ret_ff;
            end
         end
         // write three header words
         S_WR: begin
            cmd.addr_sel = asel_ff;
            cmd.word     = wcnt_ff;
            cmd.mem_wr   = 1'b1;
            cmd.wsel     = wsel_ff;
            wcnt_in      = wcnt_ff + 2'd1;
            if (wcnt_ff == 2'd2) begin
               state_in = ret_ff;
            end
         end
         // relink: rewrite next of the target filtered, then its prev
         S_SP: begin
            cmd.addr_sel = ADR_ANEXT;
            wcnt_in      = wcnt_ff + 2'd1;
            case (wcnt_ff)
               2'd0: begin
                  cmd.word   = 2'd1;
                  cmd.mem_rd = 1'b1;
               end
               2'd1: begin
                  cmd.word   = 2'd1;
                  cmd.mem_wr = 1'b1;
                  cmd.wsel   = WS_SPN;
               end
               default: begin
                  cmd.word   = 2'd2;
                  cmd.mem_wr = 1'b1;
                  cmd.wsel   = WS_SPV;
                  state_in   = ret_ff;
               end
            endcase
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/core/ffha_dpath.sv =====
// ffha_dpath: header memory, block registers and checks of the heap allocator
// depends on ffha_pkg; driven by ffha_ctrl
module ffha_dpath
   import ffha_pkg::*;
#(
   parameter int HEAP_WORDS = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_wdata,
   input  logic [1:0]  req_kind,
   input  logic [18:0] req_request_size,
   input  logic [31:0] req_release_pointer,
   input  cmd_type     cmd,
   output stat_type    stat,
   output logic        rsp_valid,
   output logic [31:0] rsp_result_pointer,
   output logic [2:0]  rsp_status
);

   localparam int          IW        = $clog2(HEAP_WORDS);
   localparam int          SW        = $clog2(HEAP_WORDS + 1);
   localparam logic [31:0] CAP_BYTES = 32'(HEAP_WORDS * 4);
   localparam logic [SW-1:0] STEP_MAX = SW'(HEAP_WORDS);

   function automatic logic hdr_ok(input logic [31:0] a, input logic [31:0] base,
                                   input logic [31:0] region);
      logic [31:0] off;
      logic [32:0] top;
      off = a - base;
      top = {1'b0, off} + {1'b0, HDR_BYTES};
      return (a != 32'd0) && (a >= base) && (a <= HDR_ADDR_MAX) &&
             (off[1:0] == 2'b00) && (top <= {1'b0, region});
   endfunction

   logic [31:0]   base_ff;
   logic [18:0]   heap_size_ff;
   logic          ready_ff;
   kind_type      kind_ff;
   logic [18:0]   req_size_ff;
   logic [31:0]   rel_ff;
   logic [31:0]   cur_ff;
   logic [SW-1:0] steps_ff;
   logic [32:0]   na_ff;
   logic [30:0]   a_size_ff, b_size_ff;
   logic          a_used_ff, b_used_ff;
   logic [31:0]   a_next_ff, a_prev_ff, b_next_ff, b_prev_ff;
   logic [31:0]   spv_ff;
   logic [31:0]   mem_q_ff;
   logic          rsp_valid_ff;
   status_type    status_ff;
   logic [31:0]   ptr_ff;

   logic [31:0]   header_store [HEAP_WORDS];

   logic [31:0]   region;
   logic [19:0]   rsz;
   logic [30:0]   rsz31;
   logic [31:0]   q_filt;
   logic [31:0]   addr;
   logic [31:0]   off_sel;
   logic [IW-1:0] idx;
   logic [31:0]   wdata;
   logic [31:0]   init_size;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= 32'd0;
         heap_size_ff <= 19'd0;
      end else if (csr_we) begin
         if (csr_index == 1'b0) begin
            base_ff <= csr_wdata;
         end else begin
            heap_size_ff <= csr_wdata[18:0];
         end
      end
   end

   // derived values
   assign region = ({13'd0, heap_size_ff} > CAP_BYTES) ? CAP_BYTES : {13'd0, heap_size_ff};
   assign rsz       = ({1'b0, req_size_ff} + 20'd3) & ~20'd3;
   assign rsz31     = {11'd0, rsz};
   assign q_filt    = hdr_ok(mem_q_ff, base_ff, region) ? mem_q_ff : 32'd0;
   assign init_size = {13'd0, heap_size_ff} - HDR_BYTES;

   // status toward the controller
   always_comb begin
      stat            = '0;
      stat.kind       = kind_ff;
      stat.init_small = (heap_size_ff <= 19'd12) || (base_ff > HDR_ADDR_MAX);
      stat.base_zero  = (base_ff == 32'd0);
      stat.ready      = ready_ff;
      stat.req_zero   = (req_size_ff == 19'd0);
      stat.req_big    = ({13'd0, req_size_ff} > region);
      stat.ptr_low    = (rel_ff == 32'd0) ||
                        ({1'b0, rel_ff} < ({1'b0, base_ff} + {1'b0, HDR_BYTES}));
      stat.cur_zero   = (cur_ff == 32'd0);
      stat.cur_ok     = hdr_ok(cur_ff, base_ff, region);
      stat.steps_done = (steps_ff == STEP_MAX);
      stat.fit        = !a_used_ff && (a_size_ff >= rsz31);
      stat.split_want = (a_size_ff > (rsz31 + 31'd16));
      stat.na_ok      = !na_ff[32] && hdr_ok(na_ff[31:0], base_ff, region);
      stat.a_used     = a_used_ff;
      stat.a_next_nz  = (a_next_ff != 32'd0);
      stat.a_prev_nz  = (a_prev_ff != 32'd0);
      stat.b_used     = b_used_ff;
   end

   // header word address
   always_comb begin
      case (cmd.addr_sel)
         ADR_BASE:  addr = base_ff;
         ADR_CUR:   addr = cur_ff;
         ADR_NA:    addr = na_ff[31:0];
         ADR_ANEXT: addr = a_next_ff;
         ADR_APREV: addr = a_prev_ff;
         default:   addr = cur_ff;
      endcase
   end
   assign off_sel = addr - base_ff;
   assign idx     = off_sel[IW+1:2] + IW'(cmd.word);

   // header write data
   always_comb begin
      wdata = 32'd0;
      case (cmd.wsel)
         WS_INIT: begin
            if (cmd.word == 2'd0) begin
               wdata = {1'b0, init_size[30:0]};
            end
         end
         WS_NEW: begin
            case (cmd.word)
               2'd0:    wdata = {1'b0, a_size_ff - rsz31 - 31'd12};
               2'd1:    wdata = a_next_ff;
               default: wdata = cur_ff;
            endcase
         end
         WS_A: begin
            case (cmd.word)
               2'd0:    wdata = {a_used_ff, a_size_ff};
               2'd1:    wdata = a_next_ff;
               default: wdata = a_prev_ff;
            endcase
         end
         WS_B: begin
            case (cmd.word)
               2'd0:    wdata = {b_used_ff, b_size_ff};
               2'd1:    wdata = b_next_ff;
               default: wdata = b_prev_ff;
            endcase
         end
         WS_SPN:  wdata = q_filt;
         WS_SPV:  wdata = spv_ff;
         default: wdata = 32'd0;
      endcase
   end

   // header memory, registered read
   always_ff @(posedge clock) begin
      if (cmd.mem_wr) begin
         header_store[idx] <= wdata;
      end
   end
   always_ff @(posedge clock) begin
      if (cmd.mem_rd) begin
         mem_q_ff <= header_store[idx];
      end
   end

   // heap ready flag
   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff <= 1'b0;
      end else if (cmd.set_ready) begin
         ready_ff <= 1'b1;
      end else if (cmd.clr_ready) begin
         ready_ff <= 1'b0;
      end
   end

   // request transaction capture
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         kind_ff     <= kind_type'(req_kind);
         req_size_ff <= req_request_size;
         rel_ff      <= req_release_pointer;
      end
   end

   // walk pointer, step count and split address
   always_ff @(posedge clock) begin
      if (cmd.cur_from_base) begin
         cur_ff <= hdr_ok(base_ff, base_ff, region) ? base_ff : 32'd0;
      end else if (cmd.cur_from_ptr) begin
         cur_ff <= rel_ff - HDR_BYTES;
      end else if (cmd.cur_from_anext) begin
         cur_ff <= a_next_ff;
      end
      if (cmd.step_clr) begin
         steps_ff <= '0;
      end else if (cmd.step_inc) begin
         steps_ff <= steps_ff + 1'b1;
      end
      if (cmd.na_load) begin
         na_ff <= {1'b0, cur_ff} + {1'b0, HDR_BYTES} + {13'd0, rsz};
      end
   end

   // block a: the block being allocated or freed
   always_ff @(posedge clock) begin
      if (cmd.cap && !cmd.cap_b) begin
         case (cmd.word)
            2'd1: begin
               a_size_ff <= mem_q_ff[30:0];
               a_used_ff <= mem_q_ff[31];
            end
            2'd2:    a_next_ff <= q_filt;
            default: a_prev_ff <= q_filt;
         endcase
      end else if (cmd.split_upd) begin
         a_size_ff <= rsz31;
         a_next_ff <= na_ff[31:0];
      end else if (cmd.merge_next) begin
         a_size_ff <= a_size_ff + 31'd12 + b_size_ff;
         a_next_ff <= b_next_ff;
      end else if (cmd.a_set_used) begin
         a_used_ff <= 1'b1;
      end else if (cmd.a_clr_used) begin
         a_used_ff <= 1'b0;
      end
   end

   // block b: a neighbor
   always_ff @(posedge clock) begin
      if (cmd.cap && cmd.cap_b) begin
         case (cmd.word)
            2'd1: begin
               b_size_ff <= mem_q_ff[30:0];
               b_used_ff <= mem_q_ff[31];
            end
            2'd2:    b_next_ff <= q_filt;
            default: b_prev_ff <= q_filt;
         endcase
      end else if (cmd.merge_prev) begin
         b_size_ff <= b_size_ff + 31'd12 + a_size_ff;
         b_next_ff <= a_next_ff;
      end
   end

   // relink value
   always_ff @(posedge clock) begin
      if (cmd.sp_load) begin
         case (cmd.spv_sel)
            SPV_NA:    spv_ff <= na_ff[31:0];
            SPV_CUR:   spv_ff <= cur_ff;
            SPV_APREV: spv_ff <= a_prev_ff;
            default:   spv_ff <= cur_ff;
         endcase
      end
   end

   // result transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.finish;
      end
      if (cmd.finish) begin
         status_ff <= cmd.status;
         ptr_ff    <= cmd.give_ptr ? (cur_ff + HDR_BYTES) : 32'd0;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_pointer = ptr_ff;
   assign rsp_status         = status_ff;

endmodule

// ===== rtl/core/first_fit_heap_allocator.sv =====
// first_fit_heap_allocator: top level of the first-fit heap allocator with coalescing
// depends on ffha_pkg, ffha_ctrl and ffha_dpath
//
//   channel   ports                       handshake
//   request   req_kind/size/pointer       start high while busy low
//   result    rsp_result_pointer/status   rsp_valid strobe, one cycle
//   config    csr_index/csr_wdata         csr_we, written at once
//
// init writes the first header; a rejected request touches no header; allocate
// reads each header it visits, then marks the block it picks (after writing the
// split-off header and relinking when it splits), and stops when nothing fits;
// free reads the block and its neighbors and merges with each one that is free.
// The header memory is single-port with a registered read.
// Reset clears the heap ready flag and the configuration registers; the header memory is
// not cleared. A result is shown for one cycle and is never held back.
module first_fit_heap_allocator
   import ffha_pkg::*;
#(
   parameter int HEAP_WORDS = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_kind,
   input  logic [18:0] req_request_size,
   input  logic [31:0] req_release_pointer,
   output logic        rsp_valid,
   output logic [31:0] rsp_result_pointer,
   output logic [2:0]  rsp_status,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   cmd_type  cmd;
   stat_type stat;

   // sequencer
   ffha_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // memory and block registers
   ffha_dpath #(
      .HEAP_WORDS (HEAP_WORDS)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_kind            (req_kind),
      .req_request_size    (req_request_size),
      .req_release_pointer (req_release_pointer),
      .cmd                 (cmd),
      .stat                (stat),
      .rsp_valid           (rsp_valid),
      .rsp_result_pointer  (rsp_result_pointer),
      .rsp_status          (rsp_status)
   );

endmodule

// ===== sim/ffha_checker.sv =====
// ffha_checker: watches the request, result and register channels of the allocator,
// predicts each result and compares it; depends on ffha_pkg only
`timescale 1ns / 1ps

module ffha_checker
   import ffha_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [1:0]  req_kind,
   input  logic [18:0] req_request_size,
   input  logic [31:0] req_release_pointer,
   input  logic        rsp_valid,
   input  logic [31:0] rsp_result_pointer,
   input  logic [2:0]  rsp_status,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output int          fail_count,
   output int          pending
);

   localparam int          WORDS     = 65536;
   localparam logic [31:0] SIZE_BITS = 32'h7FFF_FFFF;
   localparam logic [31:0] USED_BIT  = 32'h8000_0000;
   localparam logic [0:0]  REG_BASE  = 1'b0;
   localparam logic [0:0]  REG_SIZE  = 1'b1;

   typedef struct {
      logic [31:0] ptr;
      status_type  st;
   } outcome_t;

   typedef struct {
      logic [31:0] size;
      logic        used;
      logic [31:0] next;
      logic [31:0] prev;
   } header_t;

   outcome_t    outcome_q[$];
   logic [31:0] heap_words[int];
   logic [31:0] base_r;
   logic [18:0] size_r;
   logic        heap_up;

   task automatic report(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      fail_count++;
   endtask

   // usable region, capped at the store depth
   function automatic longint unsigned region_len();
      longint unsigned cap;
      cap = longint'(WORDS) * 4;
      return (size_r > cap) ? cap : longint'(size_r);
   endfunction

   // a header address that lies wholly in the region and is aligned
   function automatic bit header_ok(logic [31:0] a);
      longint unsigned off;
      if (a == 0 || a < base_r) return 0;
      if (longint'(a) + 12 > 64'hFFFF_FFFF) return 0;
      off = longint'(a) - longint'(base_r);
      if (off[1:0] != 0) return 0;
      return (off + 12) <= region_len();
   endfunction

   function automatic int word_at(logic [31:0] a, int w);
      longint unsigned idx;
      idx = ((longint'(a) - longint'(base_r)) >> 2) + w;
      return int'(idx % WORDS);
   endfunction

   function automatic logic [31:0] peek(int i);
      return heap_words.exists(i) ? heap_words[i] : 32'd0;
   endfunction

   function automatic header_t fetch(logic [31:0] a);
      header_t h;
      logic [31:0] raw;
      raw = peek(word_at(a, 0));
      h.size = raw & SIZE_BITS;
      h.used = raw[31];
      h.next = peek(word_at(a, 1));
      h.prev = peek(word_at(a, 2));
      if (!header_ok(h.next)) h.next = 0;
      if (!header_ok(h.prev)) h.prev = 0;
      return h;
   endfunction

   function automatic void store(logic [31:0] a, header_t h);
      heap_words[word_at(a, 0)] = (h.size & SIZE_BITS) | (h.used ? USED_BIT : 32'd0);
      heap_words[word_at(a, 1)] = h.next;
      heap_words[word_at(a, 2)] = h.prev;
   endfunction

   function automatic void relink_prev(logic [31:0] a, logic [31:0] p);
      header_t h;
      h = fetch(a);
      h.prev = p;
      store(a, h);
   endfunction

   function automatic status_type heap_init();
      header_t h;
      if (size_r <= 12 || longint'(base_r) + 12 > 64'hFFFF_FFFF) return ST_SMALL;
      if (base_r == 0) begin
         heap_up = 0;
         return ST_ABSENT;
      end
      heap_up = 1;
      h.size  = 32'(size_r) - 32'd12;
      h.used  = 0;
      h.next  = 0;
      h.prev  = 0;
      store(base_r, h);
      return ST_DONE;
   endfunction

   // first-fit walk with optional split
   function automatic outcome_t heap_alloc(logic [18:0] req);
      outcome_t        o;
      header_t         h, nh;
      logic [31:0]     need, cur;
      longint unsigned na;
      o.ptr = 0;
      if (!heap_up || req == 0) begin
         o.st = ST_ABSENT;
         return o;
      end
      if (longint'(req) > region_len()) begin
         o.st = ST_OOM;
         return o;
      end
      need = (32'(req) + 32'd3) & ~32'd3;
      cur  = header_ok(base_r) ? base_r : 32'd0;
      for (int steps = 0; cur != 0 && steps < WORDS; steps++) begin
         h = fetch(cur);
         if (!h.used && h.size >= need) begin
            if (h.size > need + 16) begin
               na = longint'(cur) + 12 + longint'(need);
               if (na <= 64'hFFFF_FFFF && header_ok(32'(na))) begin
                  nh.size = h.size - need - 12;
                  nh.used = 0;
                  nh.next = h.next;
                  nh.prev = cur;
                  store(32'(na), nh);
                  h.size = need;
                  h.next = 32'(na);
                  if (nh.next != 0) relink_prev(nh.next, 32'(na));
               end
            end
            h.used = 1;
            store(cur, h);
            o.ptr = cur + 32'd12;
            o.st  = ST_DONE;
            return o;
         end
         cur = h.next;
      end
      o.st = ST_OOM;
      return o;
   endfunction

   // release with merge into next, then into prev
   function automatic status_type heap_free(logic [31:0] p);
      logic [31:0] a;
      header_t     h, nb, pb;
      if (!heap_up) return ST_ABSENT;
      if (p == 0 || longint'(p) < longint'(base_r) + 12) return ST_IGNORED;
      a = p - 32'd12;
      if (!header_ok(a)) return ST_INVALID;
      h = fetch(a);
      if (!h.used) return ST_INVALID;
      h.used = 0;
      if (h.next != 0) begin
         nb = fetch(h.next);
         if (!nb.used) begin
            h.size = (h.size + 32'd12 + nb.size) & SIZE_BITS;
            h.next = nb.next;
            if (h.next != 0) relink_prev(h.next, a);
         end
      end
      if (h.prev != 0) begin
         pb = fetch(h.prev);
         if (!pb.used) begin
            pb.size = (pb.size + 32'd12 + h.size) & SIZE_BITS;
            pb.next = h.next;
            if (h.next != 0) relink_prev(h.next, h.prev);
            store(h.prev, pb);
            return ST_DONE;
         end
      end
      store(a, h);
      return ST_DONE;
   endfunction

   function automatic outcome_t predict_outcome(logic [1:0] k, logic [18:0] req,
                                                logic [31:0] p);
      outcome_t o;
      o.ptr = 0;
      o.st  = ST_DONE;
      case (kind_type'(k))
         KIND_INIT:  o.st = heap_init();
         KIND_ALLOC: o = heap_alloc(req);
         KIND_FREE:  o.st = heap_free(p);
         default:    o.st = ST_DONE;
      endcase
      return o;
   endfunction

   // compare results, track registers, predict each accepted transaction
   always @(posedge clock) begin
      outcome_t e;
      if (reset) begin
         base_r  = 0;
         size_r  = 0;
         heap_up = 0;
         outcome_q.delete();
      end else begin
         if (rsp_valid) begin
            if (outcome_q.size() == 0) begin
               report("result with no transaction outstanding");
            end else begin
               e = outcome_q.pop_front();
               if (rsp_result_pointer !== e.ptr)
                  report($sformatf("pointer %h, expected %h", rsp_result_pointer, e.ptr));
               if (rsp_status !== e.st)
                  report($sformatf("status %0d, expected %0d", rsp_status, e.st));
            end
         end
         if (csr_we) begin
            if (csr_index == REG_BASE) base_r = csr_wdata;
            else if (csr_index == REG_SIZE) size_r = csr_wdata[18:0];
         end
         if (start && !busy)
            outcome_q.push_back(predict_outcome(req_kind, req_request_size,
                                                req_release_pointer));
      end
      pending = outcome_q.size();
   end

endmodule

// ===== sim/tb.sv =====
// tb: drives requests and register writes into first_fit_heap_allocator and gives
// the verdict; depends on ffha_pkg, the allocator RTL and ffha_checker
`timescale 1ns / 1ps

module tb;
   import ffha_pkg::*;

   localparam logic [0:0] REG_BASE = 1'b0;
   localparam logic [0:0] REG_SIZE = 1'b1;

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic [1:0]  req_kind = KIND_NOP;
   logic [18:0] req_request_size = 0;
   logic [31:0] req_release_pointer = 0;
   logic        rsp_valid;
   logic [31:0] rsp_result_pointer;
   logic [2:0]  rsp_status;
   logic        csr_we = 0;
   logic [0:0]  csr_index = REG_BASE;
   logic [31:0] csr_wdata = 0;
   int          fail_count;
   int          pending;

   logic [31:0] granted_q[$];
   logic [31:0] cur_base;
   logic [18:0] cur_size;

   always #4 clock = ~clock;

   first_fit_heap_allocator u_top (.*);

   ffha_checker u_chk (.*);

   // remember pointers handed out, the pool for free transactions
   always @(posedge clock) begin
      if (rsp_valid && rsp_status == ST_DONE && rsp_result_pointer != 0)
         granted_q.push_back(rsp_result_pointer);
   end

   // short idle gap, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // hold the transaction until the edge that accepts it, then return after it
   task automatic send(input kind_type k, input logic [18:0] sz, input logic [31:0] p,
                       input int gap);
      repeat (gap) begin
         @(negedge clock);
         start <= 0;
      end
      @(negedge clock);
      start               <= 1;
      req_kind            <= k;
      req_request_size    <= sz;
      req_release_pointer <= p;
      while (busy) @(negedge clock);
      @(posedge clock);
   endtask

   // let outstanding work drain before touching registers
   task automatic settle();
      @(negedge clock);
      start <= 0;
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
      @(negedge clock);
      csr_we    <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 0;
   endtask

   task automatic set_heap(input logic [31:0] b, input logic [18:0] s);
      settle();
      if (b != cur_base) granted_q.delete();
      write_reg(REG_BASE, b);
      // upper data bits are dropped by the size register
      write_reg(REG_SIZE, {13'($urandom_range(0, 8191)), s});
      cur_base = b;
      cur_size = s;
   endtask

   // mostly alloc and free of live blocks, plus malformed frees and re-inits
   task automatic random_traffic(input int n);
      int          r, idx;
      logic [31:0] p, lim;
      logic [18:0] sz;
      lim = (cur_size > 19'd262144) ? 32'd262144 : 32'(cur_size);
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 45 || (r < 85 && granted_q.size() == 0)) begin
            r = $urandom_range(0, 99);
            if (r < 60) sz = 19'($urandom_range(1, 64));
            else if (r < 80) sz = 19'($urandom_range(65, 1024));
            else if (r < 88) sz = 19'($urandom_range(1, (lim == 0) ? 1 : lim));
            else if (r < 92) sz = 0;
            else sz = 19'h40000 | 19'($urandom);
            send(KIND_ALLOC, sz, $urandom, pick_gap());
         end else if (r < 85) begin
            idx = $urandom_range(0, granted_q.size() - 1);
            p   = granted_q[idx];
            if ($urandom_range(0, 4) != 0) granted_q.delete(idx);
            send(KIND_FREE, 19'($urandom), p, pick_gap());
         end else if (r < 95) begin
            r = $urandom_range(0, 3);
            if (r == 0) p = 0;
            else if (r == 1) p = cur_base + $urandom_range(0, 11);
            else if (r == 2) p = cur_base + lim + 32'd12 + 4 * $urandom_range(0, 1000);
            else if (granted_q.size() != 0)
               p = granted_q[$urandom_range(0, granted_q.size() - 1)] + $urandom_range(1, 3);
            else p = 0;
            send(KIND_FREE, 19'($urandom), p, pick_gap());
         end else if (r < 98) begin
            send(KIND_NOP, 19'($urandom), $urandom, pick_gap());
         end else begin
            send(KIND_INIT, 19'($urandom), $urandom, pick_gap());
         end
      end
   endtask

   initial begin
      cur_base = 0;
      cur_size = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // no heap yet
      send(KIND_ALLOC, 19'd4, 32'hFFFF_FFFF, 0);
      send(KIND_FREE, 19'h7FFFF, 32'hFFFF_FFFF, 0);
      send(KIND_NOP, 19'h7FFFF, 32'hFFFF_FFFF, 1);
      send(KIND_INIT, 0, 0, 0);

      // tiny heap: exact fit, oversize, bad and double frees
      set_heap(32'h0000_1000, 19'd64);
      send(KIND_INIT, 0, 0, 0);
      send(KIND_ALLOC, 19'd1, 0, 0);
      send(KIND_ALLOC, 19'd0, 0, 0);
      send(KIND_ALLOC, 19'h7FFFF, 0, 0);
      send(KIND_ALLOC, 19'd64, 0, 2);
      send(KIND_FREE, 0, 32'd0, 0);
      send(KIND_FREE, 0, 32'h0000_1004, 0);
      send(KIND_FREE, 0, 32'h0000_100D, 0);
      send(KIND_FREE, 0, 32'h0000_100C, 0);
      send(KIND_FREE, 0, 32'h0000_100C, 0);
      send(KIND_FREE, 0, 32'h0000_2000, 0);
      send(KIND_ALLOC, 19'd52, 0, 0);
      send(KIND_ALLOC, 19'd8, 0, 0);
      send(KIND_FREE, 0, 32'h0000_100C, 3);

      // degenerate settings: base at the top, base zero, size zero
      set_heap(32'hFFFF_FFFF, 19'd100);
      send(KIND_INIT, 0, 0, 0);
      set_heap(32'h0000_0000, 19'd1000);
      send(KIND_INIT, 0, 0, 0);
      send(KIND_ALLOC, 19'd4, 0, 0);
      set_heap(32'h0000_4000, 19'd0);
      send(KIND_INIT, 0, 0, 0);

      // working heaps of several shapes
      set_heap(32'h0000_1000, 19'd4096);
      send(KIND_INIT, 0, 0, 0);
      random_traffic(180);
      set_heap(32'h8000_0002, 19'd13);
      send(KIND_INIT, 0, 0, 0);
      random_traffic(20);
      set_heap(32'hFFF0_0000, 19'd262144);
      send(KIND_INIT, 0, 0, 0);
      random_traffic(180);
      set_heap(32'h0000_0010, 19'h7FFFF);
      send(KIND_INIT, 0, 0, 0);
      random_traffic(150);
      set_heap(32'h1234_5678, 19'd200);
      send(KIND_INIT, 0, 0, 0);
      random_traffic(120);
      set_heap(32'h0000_1000, 19'd1024);
      send(KIND_INIT, 0, 0, 0);
      random_traffic(120);

      settle();
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // run limit
   initial begin
      #40ms;
      $display("== FAIL ==");
      $finish;
   end

endmodule
